[rtl/pbn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_pkg
// Shared types and constants of the palette blend nearest-color unit.
// ----------------------------------------------------------------------------
package pbn_pkg;

  localparam int IDX_W  = 8;
  localparam int COMP_W = 8;
  localparam int RGB_W  = 3 * COMP_W;
  localparam int PCT_W  = 7;

  localparam int PERCENT_MAX   = 100;
  localparam int PERCENT_RESET = 80;

  localparam int PALETTE_ENTRIES_DEF  = 256;
  localparam int WEIGHT_FRAC_BITS_DEF = 12;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_BACK,
    ST_RD_FRONT,
    ST_MIX,
    ST_SCAN,
    ST_DRAIN
  } seq_state_t;

  // sequencer to score unit
  typedef struct packed {
    logic             vld;
    logic             blend_mode;
    logic [IDX_W-1:0] idx;
  } score_ctl_t;

  // score unit to sequencer
  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] best_idx;
  } score_stat_t;

endpackage

[rtl/pbn_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_req_if
// Request channel: palette loads and blend queries.
// ----------------------------------------------------------------------------
interface pbn_req_if
  import pbn_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  entry_index;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;
  logic [IDX_W-1:0]  back_color;
  logic [IDX_W-1:0]  front_color;

  modport source (
    output valid, action, entry_index, red, green, blue, back_color, front_color,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, red, green, blue, back_color, front_color,
    output ready
  );
endinterface

[rtl/pbn_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_rsp_if
// Response channel: nearest palette index of a query.
// ----------------------------------------------------------------------------
interface pbn_rsp_if
  import pbn_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] blended_color;

  modport source (output valid, blended_color, input ready);
  modport sink (input valid, blended_color, output ready);
endinterface

[rtl/pbn_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_cfg_if
// Configuration write channel for the filter percent register.
// ----------------------------------------------------------------------------
interface pbn_cfg_if
  import pbn_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] filter_percent;

  modport source (output valid, filter_percent, input ready);
  modport sink (input valid, filter_percent, output ready);
endinterface

[rtl/pbn_palette_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_palette_mem
// Palette storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbn_palette_mem
  import pbn_pkg::*;
#(
  parameter int DEPTH = PALETTE_ENTRIES_DEF,
  parameter int AW    = $clog2(PALETTE_ENTRIES_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [RGB_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [RGB_W-1:0] rdata
);

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/pbn_score_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_score_unit
// Shared three-lane multiply unit. Forms the blend once per query, then
// scores one palette entry per beat and keeps the lowest error.
// ----------------------------------------------------------------------------
module pbn_score_unit
  import pbn_pkg::*;
#(
  parameter int ENTRIES   = PALETTE_ENTRIES_DEF,
  parameter int FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  score_ctl_t           ctl,
  input  logic [RGB_W-1:0]     color_a,
  input  logic [RGB_W-1:0]     color_b,
  input  logic [FRAC_BITS:0]   wf,
  output score_stat_t          stat
);

  localparam int BW = FRAC_BITS + COMP_W;      // blend component
  localparam int DW = FRAC_BITS + COMP_W + 1;  // signed distance operand
  localparam int PW = DW + COMP_W + 1;         // product
  localparam int EW = PW + 2;                  // sum of three products
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [BW-1:0]        blend [3];
  logic signed [PW-1:0] prod  [3];
  logic signed [PW-1:0] prod_next [3];
  logic                 pv;
  logic                 pblend;
  logic [IDX_W-1:0]     pidx;
  logic signed [EW-1:0] best;
  logic [IDX_W-1:0]     best_idx;
  logic signed [EW-1:0] err;

  always_comb begin
    logic [COMP_W-1:0]    ca;
    logic [COMP_W-1:0]    cb;
    logic signed [COMP_W:0] op_a;
    logic signed [DW-1:0] op_b;
    logic [DW-1:0]        shl;
    for (int k = 0; k < 3; k++) begin
      ca  = color_a[k*COMP_W +: COMP_W];
      cb  = color_b[k*COMP_W +: COMP_W];
      shl = DW'(ca) << (FRAC_BITS - 1);
      if (ctl.blend_mode) begin
        // front minus back, scaled by the front weight
        op_a = $signed({1'b0, ca}) - $signed({1'b0, cb});
        op_b = $signed(DW'(wf));
      end else begin
        // c * (c * half - blend)
        op_a = $signed({1'b0, ca});
        op_b = $signed(shl) - $signed({1'b0, blend[k]});
      end
      prod_next[k] = PW'(op_a) * PW'(op_b);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod[k] <= prod_next[k];
    end
    pblend <= ctl.blend_mode;
    pidx   <= ctl.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.vld;
    end
  end

  assign err = EW'(prod[0]) + EW'(prod[1]) + EW'(prod[2]);

  always_ff @(posedge clk) begin
    logic [PW-1:0] bsum;
    if (pv && pblend) begin
      for (int k = 0; k < 3; k++) begin
        bsum     = (PW'(color_b[k*COMP_W +: COMP_W]) << FRAC_BITS) + prod[k];
        blend[k] <= bsum[BW-1:0];
      end
    end
    // highest index is scored first; strict compare keeps it on ties
    if (pv && !pblend && (pidx == LAST_IDX || err < best)) begin
      best     <= err;
      best_idx <= pidx;
    end
  end

  assign stat.busy     = pv;
  assign stat.best_idx = best_idx;

endmodule

[rtl/pbn_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbn_seq
// Sequencer: takes loads and queries, fetches the two query colors, runs
// the palette scan through the score unit and holds the result.
// ----------------------------------------------------------------------------
module pbn_seq
  import pbn_pkg::*;
#(
  parameter int ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int AW      = $clog2(PALETTE_ENTRIES_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  pbn_req_if.sink          req,
  pbn_rsp_if.source        rsp,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [RGB_W-1:0] mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [RGB_W-1:0] mem_rdata,
  output score_ctl_t       ctl,
  output logic [RGB_W-1:0] color_a,
  output logic [RGB_W-1:0] color_b,
  input  score_stat_t      stat
);

  localparam logic [IDX_W:0] IDX_LIM = (IDX_W + 1)'(ENTRIES);
  localparam logic [AW-1:0]  LAST    = AW'(ENTRIES - 1);

  seq_state_t       state;
  seq_state_t       state_next;
  logic [IDX_W-1:0] back_idx;
  logic [IDX_W-1:0] front_idx;
  logic             back_oob;
  logic             front_oob;
  logic [RGB_W-1:0] back_rgb;
  logic [AW-1:0]    cnt;
  logic             dv;
  logic [AW-1:0]    didx;
  logic             out_valid;
  logic [IDX_W-1:0] out_color;
  logic             accept;
  logic             finish;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign mem_we    = accept && (req.action == ACT_LOAD) && ({1'b0, req.entry_index} < IDX_LIM);
  assign mem_waddr = req.entry_index[AW-1:0];
  assign mem_wdata = {req.red, req.green, req.blue};

  // result may overwrite the output register once it is free or being taken
  assign finish = (state == ST_DRAIN) && !dv && !stat.busy && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_raddr  = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.action == ACT_QUERY) begin
          state_next = ST_RD_BACK;
        end
      end
      ST_RD_BACK: begin
        mem_raddr  = back_idx[AW-1:0];
        state_next = ST_RD_FRONT;
      end
      ST_RD_FRONT: begin
        mem_raddr  = front_idx[AW-1:0];
        state_next = ST_MIX;
      end
      ST_MIX: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      back_idx  <= req.back_color;
      front_idx <= req.front_color;
      back_oob  <= !({1'b0, req.back_color} < IDX_LIM);
      front_oob <= !({1'b0, req.front_color} < IDX_LIM);
    end
    if (state == ST_RD_FRONT) begin
      back_rgb <= back_oob ? '0 : mem_rdata;
    end
    if (state == ST_MIX) begin
      cnt <= LAST;
    end else if (state == ST_SCAN) begin
      cnt <= cnt - 1'b1;
    end
    didx <= cnt;
    if (finish) begin
      out_color <= stat.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv <= (state == ST_SCAN);
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // front color enters the unit in the mix beat, palette entries after it
  always_comb begin
    ctl.vld        = (state == ST_MIX) || dv;
    ctl.blend_mode = (state == ST_MIX);
    ctl.idx        = IDX_W'(didx);
    color_a        = mem_rdata;
    if (state == ST_MIX && front_oob) begin
      color_a = '0;
    end
  end

  assign color_b = back_rgb;

  assign rsp.valid         = out_valid;
  assign rsp.blended_color = out_color;

endmodule

[rtl/palette_blend_nearest_color_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_blend_nearest_color_unit
// Blends two palette colors by a percent weight and returns the index of
// the nearest palette entry.
// ----------------------------------------------------------------------------
// channel | dir | beat carries
// req     | in  | action, entry_index, red, green, blue, back_color, front_color
// rsp     | out | blended_color
// cfg     | in  | filter_percent (always ready)
//
// a load does not leave idle; the next beat can be taken on the following cycle.
// a query reads its back and front colors, blends them, then scans the palette:
// the palette read port and the shared score unit handle one entry a cycle.
// req is held off while a query runs; a finished result waits in the output
// register without blocking new beats. rst is synchronous and clears control
// state; the palette is undefined until loaded.
// ----------------------------------------------------------------------------
module palette_blend_nearest_color_unit
  import pbn_pkg::*;
#(
  parameter int PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pbn_req_if.sink   req,
  pbn_rsp_if.source rsp,
  pbn_cfg_if.sink   cfg
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [PCT_W-1:0] PCT_SAT = PCT_W'(PERCENT_MAX);

  typedef logic [WEIGHT_FRAC_BITS:0] wtab_t [PERCENT_MAX + 1];

  // front weight for each percent, floor(pct * one / 100)
  function automatic wtab_t build_wtab();
    wtab_t t;
    for (int i = 0; i <= PERCENT_MAX; i++) begin
      t[i] = (WEIGHT_FRAC_BITS + 1)'((i * (1 << WEIGHT_FRAC_BITS)) / PERCENT_MAX);
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  logic [WEIGHT_FRAC_BITS:0] wf;
  logic [PCT_W-1:0]          pct_sat;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [RGB_W-1:0]          mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [RGB_W-1:0]          mem_rdata;
  score_ctl_t                ctl;
  score_stat_t               stat;
  logic [RGB_W-1:0]          color_a;
  logic [RGB_W-1:0]          color_b;

  assign cfg.ready = 1'b1;
  assign pct_sat   = (cfg.filter_percent > PCT_SAT) ? PCT_SAT : cfg.filter_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      wf <= WTAB[PERCENT_RESET];
    end else if (cfg.valid && cfg.ready) begin
      wf <= WTAB[pct_sat];
    end
  end

  pbn_palette_mem #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pbn_score_unit #(
    .ENTRIES   (PALETTE_ENTRIES),
    .FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_score (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .color_a (color_a),
    .color_b (color_b),
    .wf      (wf),
    .stat    (stat)
  );

  pbn_seq #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .ctl       (ctl),
    .color_a   (color_a),
    .color_b   (color_b),
    .stat      (stat)
  );

endmodule
